// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/swpd_pkg.sv =====
// Package for the sync word packet deframer: widths, codes and shared types.
// Depends on nothing; used by the interfaces, the parser and the top level.
`default_nettype none

package swpd_pkg;

	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = 16;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [31:0] SYNC_WORD = 32'hEF02_AAAA;
	localparam logic [BYTE_W-1:0] SYNC_SUM =
		BYTE_W'(8'hEF + 8'h02 + 8'hAA + 8'hAA);

	// header bytes that land in the shadow: target, source, index, function
	localparam int SHADOW_BYTES = 7;
	localparam int HDR_LEN_LO   = 7;
	localparam int HDR_LEN_HI   = 8;

	localparam logic [KIND_W-1:0] EV_HDR_OK   = 3'd0;
	localparam logic [KIND_W-1:0] EV_PAYLOAD  = 3'd1;
	localparam logic [KIND_W-1:0] EV_GOOD     = 3'd2;
	localparam logic [KIND_W-1:0] EV_BAD_PAY  = 3'd3;
	localparam logic [KIND_W-1:0] EV_BAD_HDR  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR = 2'd1;

	typedef struct packed {
		logic [ADDR_W-1:0] local_address;
		logic [ADDR_W-1:0] broadcast_address;
	} swpd_cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [ADDR_W-1:0] target_address;
		logic [ADDR_W-1:0] source_address;
		logic [ADDR_W-1:0] packet_index;
		logic [BYTE_W-1:0] function_code;
		logic [ADDR_W-1:0] payload_length;
		logic [BYTE_W-1:0] payload_byte;
		logic              for_this_node;
		logic              frame_last;
	} swpd_event_t;

endpackage

`default_nettype wire

// ===== hdl/swpd_rx_if.sv =====
// Word channels of the deframer: received bytes in, events out.
// Depends on swpd_pkg.
`default_nettype none

interface swpd_rx_if import swpd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface swpd_event_if import swpd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] event_kind;
	logic [ADDR_W-1:0] target_address;
	logic [ADDR_W-1:0] source_address;
	logic [ADDR_W-1:0] packet_index;
	logic [BYTE_W-1:0] function_code;
	logic [ADDR_W-1:0] payload_length;
	logic [BYTE_W-1:0] payload_byte;
	logic              for_this_node;
	logic              frame_last;

	modport source (output valid, output event_kind, output target_address,
		output source_address, output packet_index, output function_code,
		output payload_length, output payload_byte, output for_this_node,
		output frame_last, input ready);
	modport sink (input valid, input event_kind, input target_address,
		input source_address, input packet_index, input function_code,
		input payload_length, input payload_byte, input for_this_node,
		input frame_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/sync_word_packet_deframer_unit.sv =====
// Sync word packet deframer, top level: config registers, parser, event register.
// Depends on swpd_pkg, swpd_rx_if, swpd_event_if, swpd_parser, assert_macros.svh.
//
// Usage:
//   rx_ch carries one received byte per word. The block hunts for EF 02 AA AA,
//   gathers the 9-byte little-endian header and its checksum, then passes the
//   payload through and checks the trailing payload checksum.
//   event_ch carries at most one event per received byte: header ok, payload
//   byte, packet good, payload checksum bad, header checksum bad. Sync bytes
//   and header bytes before the checksum byte produce no event.
//   cfg_we/cfg_index/cfg_wdata write local_address (index 0) and
//   broadcast_address (index 1); other indexes are ignored.
// Timing:
//   One byte per cycle sustained. An event appears on event_ch the cycle after
//   its byte is taken; the state update is a compare, an add and a byte insert.
//   rx_ch.ready stays high while the event register is empty or being drained,
//   so a stalled receiver holds off input only while an event is waiting.
// Reset:
//   arst_n clears the parser to hunting with an empty window, empties the
//   event register and sets local_address to 0 and broadcast_address to FFFF.
`default_nettype none

module sync_word_packet_deframer_unit import swpd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	swpd_rx_if.sink                   rx_ch,
	swpd_event_if.source              event_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	`include "assert_macros.svh"

	swpd_cfg_t   cfg_q;
	logic        step;
	logic        evt_valid;
	logic        evt_load;
	swpd_event_t evt;
	logic        out_valid_q;
	swpd_event_t out_evt_q;
	logic        out_last_kind;
	logic        out_hdr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_address     <= '0;
			cfg_q.broadcast_address <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCAL_ADDR: cfg_q.local_address     <= cfg_wdata[ADDR_W-1:0];
				REG_BCAST_ADDR: cfg_q.broadcast_address <= cfg_wdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	assign rx_ch.ready = !out_valid_q || event_ch.ready;
	assign step        = rx_ch.valid && rx_ch.ready;
	assign evt_load    = step && evt_valid;

	swpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (rx_ch.rx_byte),
		.cfg       (cfg_q),
		.evt_valid (evt_valid),
		.evt       (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (evt_load) begin
			out_valid_q <= 1'b1;
		end else if (event_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_load)
			out_evt_q <= evt;
	end

	assign event_ch.valid          = out_valid_q;
	assign event_ch.event_kind     = out_evt_q.event_kind;
	assign event_ch.target_address = out_evt_q.target_address;
	assign event_ch.source_address = out_evt_q.source_address;
	assign event_ch.packet_index   = out_evt_q.packet_index;
	assign event_ch.function_code  = out_evt_q.function_code;
	assign event_ch.payload_length = out_evt_q.payload_length;
	assign event_ch.payload_byte   = out_evt_q.payload_byte;
	assign event_ch.for_this_node  = out_evt_q.for_this_node;
	assign event_ch.frame_last     = out_evt_q.frame_last;

	assign out_last_kind = (out_evt_q.event_kind == EV_GOOD) ||
		(out_evt_q.event_kind == EV_BAD_PAY) || (out_evt_q.event_kind == EV_BAD_HDR);
	assign out_hdr_ok    = (out_evt_q.event_kind == EV_HDR_OK);

	`ASSERT_IMPLIES(a_last_kind, clk, arst_n, out_valid_q, out_evt_q.frame_last == out_last_kind)
	`ASSERT_IMPLIES(a_stall_blocks, clk, arst_n, out_valid_q && !event_ch.ready, !rx_ch.ready)
	`ASSERT_IMPLIES(a_node_hdr_only, clk, arst_n, out_valid_q && out_evt_q.for_this_node, out_hdr_ok)
	`ASSERT_NEXT(a_event_loaded, clk, arst_n, evt_load, out_valid_q && (out_evt_q == $past(evt)))

endmodule

`default_nettype wire

// ===== hdl/swpd_parser.sv =====
// Frame parser: sync hunt, header gather, payload pass-through and checksums.
// One byte per step; depends on swpd_pkg.
`default_nettype none

module swpd_parser import swpd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire swpd_cfg_t         cfg,
	output logic                   evt_valid,
	output swpd_event_t            evt
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	phase_t                      phase_q, phase_d;
	logic [23:0]                 win_q, win_d;
	logic [3:0]                  hcnt_q, hcnt_d;
	logic [8*SHADOW_BYTES-1:0]   shadow_q, shadow_d;
	logic [BYTE_W-1:0]           hsum_q, hsum_d;
	logic [ADDR_W-1:0]           prem_q, prem_d;
	logic [BYTE_W-1:0]           psum_q, psum_d;
	logic [ADDR_W-1:0]           tgt;

	assign tgt = shadow_q[ADDR_W-1:0];

	always_comb begin
		phase_d   = phase_q;
		win_d     = win_q;
		hcnt_d    = hcnt_q;
		shadow_d  = shadow_q;
		hsum_d    = hsum_q;
		prem_d    = prem_q;
		psum_d    = psum_q;
		evt_valid = 1'b0;
		evt       = '0;
		unique case (phase_q)
			PH_HUNT: begin
				win_d = {win_q[15:0], rx_byte};
				if ({win_q, rx_byte} == SYNC_WORD) begin
					phase_d = PH_HEADER;
					win_d   = '0;
					hcnt_d  = '0;
					hsum_d  = SYNC_SUM;
				end
			end
			PH_HEADER: begin
				if (hcnt_q < 4'(HDR_LEN_HI + 1)) begin
					hsum_d = hsum_q + rx_byte;
					hcnt_d = hcnt_q + 4'd1;
					for (int i = 0; i < SHADOW_BYTES; i++) begin
						if (hcnt_q == 4'(i))
							shadow_d[8*i +: 8] = rx_byte;
					end
					if (hcnt_q == 4'(HDR_LEN_LO))
						prem_d[7:0] = rx_byte;
					if (hcnt_q == 4'(HDR_LEN_HI))
						prem_d[15:8] = rx_byte;
				end else begin
					evt_valid          = 1'b1;
					evt.target_address = tgt;
					evt.source_address = shadow_q[31:16];
					evt.packet_index   = shadow_q[47:32];
					evt.function_code  = shadow_q[55:48];
					evt.payload_length = prem_q;
					if (rx_byte != hsum_q) begin
						evt.event_kind = EV_BAD_HDR;
						evt.frame_last = 1'b1;
						phase_d = PH_HUNT;
						win_d   = '0;
						hcnt_d  = '0;
						hsum_d  = '0;
						psum_d  = '0;
					end else begin
						evt.event_kind    = EV_HDR_OK;
						evt.for_this_node = (tgt == cfg.local_address) ||
							(tgt == cfg.broadcast_address);
						hcnt_d  = '0;
						psum_d  = '0;
						phase_d = (prem_q == '0) ? PH_CHECK : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				evt_valid        = 1'b1;
				evt.event_kind   = EV_PAYLOAD;
				evt.payload_byte = rx_byte;
				psum_d = psum_q + rx_byte;
				prem_d = prem_q - 16'd1;
				if (prem_q == 16'd1)
					phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				evt_valid      = 1'b1;
				evt.event_kind = (rx_byte == psum_q) ? EV_GOOD : EV_BAD_PAY;
				evt.frame_last = 1'b1;
				phase_d = PH_HUNT;
				win_d   = '0;
				hcnt_d  = '0;
				hsum_d  = '0;
				psum_d  = '0;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			win_q   <= '0;
			hcnt_q  <= '0;
			hsum_q  <= '0;
			psum_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			win_q   <= win_d;
			hcnt_q  <= hcnt_d;
			hsum_q  <= hsum_d;
			psum_q  <= psum_d;
		end
	end

	// every field is written during the header before it is read
	always_ff @(posedge clk) begin
		if (step) begin
			shadow_q <= shadow_d;
			prem_q   <= prem_d;
		end
	end

endmodule

`default_nettype wire
